FILE: sv/x86_logic_shift_alu_macros.svh
// ----------------------------------------------------------------------------
// x86_logic_shift_alu assertion macros
// shared concurrent assertion forms, clocked on clock and cut off in reset
// ----------------------------------------------------------------------------
`ifndef X86_LOGIC_SHIFT_ALU_MACROS_SVH
`define X86_LOGIC_SHIFT_ALU_MACROS_SVH

// same-cycle implication
`define XLSA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define XLSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/xlsa_pkg.sv
// ----------------------------------------------------------------------------
// xlsa_pkg
// operation and width codes, field widths for the logic and shift unit
// ----------------------------------------------------------------------------
package xlsa_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned FuncWidth  = 4;
   localparam int unsigned WCodeWidth = 2;
   localparam int unsigned CountWidth = 5;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_TEST = 4'd0,
      FUNC_AND  = 4'd1,
      FUNC_XOR  = 4'd2,
      FUNC_OR   = 4'd3,
      FUNC_ROL  = 4'd4,
      FUNC_SAR  = 4'd5,
      FUNC_SHL  = 4'd6,
      FUNC_SHR  = 4'd7,
      FUNC_NOT  = 4'd8
   } alu_func_type;

   typedef enum logic [WCodeWidth-1:0] {
      WIDTH_BYTE  = 2'd0,
      WIDTH_WORD  = 2'd1,
      WIDTH_DWORD = 2'd2
   } width_code_type;

endpackage

FILE: sv/xlsa_req_if.sv
// ----------------------------------------------------------------------------
// xlsa_req_if
// request channel: operation, operand width and both operand values
// ----------------------------------------------------------------------------
interface xlsa_req_if
   import xlsa_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [FuncWidth-1:0]  func;
   logic [WCodeWidth-1:0] width_code;
   logic [DataWidth-1:0]  dest_value;
   logic [DataWidth-1:0]  src_value;

   modport source (output valid, func, width_code, dest_value, src_value, input ready);
   modport sink   (input valid, func, width_code, dest_value, src_value, output ready);
endinterface

FILE: sv/xlsa_rsp_if.sv
// ----------------------------------------------------------------------------
// xlsa_rsp_if
// response channel: truncated result, write-back mark and flags
// ----------------------------------------------------------------------------
interface xlsa_rsp_if
   import xlsa_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] result;
   logic                 write_back;
   logic                 zero_flag;
   logic                 sign_flag;
   logic                 zs_valid;
   logic                 carry_flag;
   logic                 overflow_flag;
   logic                 co_valid;

   modport source (output valid, result, write_back, zero_flag, sign_flag, zs_valid,
                   carry_flag, overflow_flag, co_valid, input ready);
   modport sink   (input valid, result, write_back, zero_flag, sign_flag, zs_valid,
                   carry_flag, overflow_flag, co_valid, output ready);
endinterface

FILE: sv/x86_logic_shift_alu.sv
// ----------------------------------------------------------------------------
// x86_logic_shift_alu
// logic, rotate and shift unit for 8, 16 and 32 bit operands with flags
// ----------------------------------------------------------------------------
// Usage:
//   req_chan (valid/ready) carries one operation per beat: func, width_code,
//   dest_value and src_value. rsp_chan (valid/ready) returns one beat per
//   request: result truncated to the operand width, write_back, zero/sign
//   flags with zs_valid and carry/overflow flags with co_valid.
//   A beat is taken into an input register, evaluated by short combinational
//   logic (mask, logic op or barrel shift, flag compare) and captured in the
//   result register, which drives the response beat. Throughput is one beat
//   per cycle while rsp_chan takes each response, set by the two register
//   stages, each of which refills in the cycle it empties.
//   When rsp_chan stalls the result register holds; an empty input register
//   still takes one more beat, and req_chan.ready is low while both stages
//   are full and the response is not taken.
//   Synchronous reset empties both stages; the data registers are not reset.
//   Width code 3 acts as dword; func 9 to 15 returns zero with no write-back
//   and no flags.
// ----------------------------------------------------------------------------
`include "x86_logic_shift_alu_macros.svh"

module x86_logic_shift_alu
   import xlsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   xlsa_req_if.sink   req_chan,
   xlsa_rsp_if.source rsp_chan
);

   // input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [FuncWidth-1:0]  s1_func_ff;
   logic [WCodeWidth-1:0] s1_wcode_ff;
   logic [DataWidth-1:0]  s1_dest_ff;
   logic [DataWidth-1:0]  s1_src_ff;

   // result stage
   logic                 s2_valid_ff, s2_valid_in;
   logic [DataWidth-1:0] s2_result_ff, s2_result_in;
   logic                 s2_wb_ff, s2_wb_in;
   logic                 s2_zf_ff, s2_zf_in;
   logic                 s2_sf_ff, s2_sf_in;
   logic                 s2_zs_ff, s2_zs_in;
   logic                 s2_co_ff, s2_co_in;

   logic s2_load;
   logic s1_load;
   logic req_beat;

   // datapath signals
   logic [DataWidth-1:0]   mask;
   logic [DataWidth-1:0]   top;
   logic [DataWidth-1:0]   d_val;
   logic [DataWidth-1:0]   s_val;
   logic [CountWidth-1:0]  cnt;
   logic [DataWidth-1:0]   d_sext;
   logic [DataWidth-1:0]   sar_val;
   logic [DataWidth-1:0]   rol_val;
   logic [2*8-1:0]         rol_b;
   logic [2*16-1:0]        rol_w;
   logic [2*DataWidth-1:0] rol_d;

   assign s2_load  = !s2_valid_ff || rsp_chan.ready;
   assign s1_load  = !s1_valid_ff || (s2_load);
   assign req_beat = req_chan.valid && req_chan.ready;

   assign req_chan.ready = s1_load;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = req_chan.valid;
      end
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_func_ff  <= req_chan.func;
         s1_wcode_ff <= req_chan.width_code;
         s1_dest_ff  <= req_chan.dest_value;
         s1_src_ff   <= req_chan.src_value;
      end
   end

   // width decode, code 3 behaves as dword
   always_comb begin
      case (width_code_type'(s1_wcode_ff))
         WIDTH_BYTE: begin
            mask   = DataWidth'(32'h0000_00ff);
            top    = DataWidth'(32'h0000_0080);
            d_sext = {{(DataWidth-8){s1_dest_ff[7]}}, s1_dest_ff[7:0]};
         end
         WIDTH_WORD: begin
            mask   = DataWidth'(32'h0000_ffff);
            top    = DataWidth'(32'h0000_8000);
            d_sext = {{(DataWidth-16){s1_dest_ff[15]}}, s1_dest_ff[15:0]};
         end
         default: begin
            mask   = '1;
            top    = {1'b1, {(DataWidth-1){1'b0}}};
            d_sext = s1_dest_ff;
         end
      endcase
   end

   assign d_val = s1_dest_ff & mask;
   assign s_val = s1_src_ff & mask;
   assign cnt   = s1_src_ff[CountWidth-1:0];

   // sar: sign taken from the top bit of the chosen width
   assign sar_val = DataWidth'($signed(d_sext) >>> cnt) & mask;

   // rotate through a doubled copy, count taken modulo the width
   assign rol_b = {d_val[7:0], d_val[7:0]} << cnt[2:0];
   assign rol_w = {d_val[15:0], d_val[15:0]} << cnt[3:0];
   assign rol_d = {d_val, d_val} << cnt;

   always_comb begin
      case (width_code_type'(s1_wcode_ff))
         WIDTH_BYTE: rol_val = {{(DataWidth-8){1'b0}}, rol_b[15:8]};
         WIDTH_WORD: rol_val = {{(DataWidth-16){1'b0}}, rol_w[31:16]};
         default:    rol_val = rol_d[2*DataWidth-1:DataWidth];
      endcase
   end

   always_comb begin
      s2_result_in = '0;
      s2_wb_in     = 1'b1;
      s2_zs_in     = 1'b0;
      s2_co_in     = 1'b0;
      case (alu_func_type'(s1_func_ff))
         FUNC_TEST: begin
            s2_result_in = d_val & s_val;
            s2_wb_in     = 1'b0;
            s2_zs_in     = 1'b1;
            s2_co_in     = 1'b1;
         end
         FUNC_AND: begin
            s2_result_in = d_val & s_val;
            s2_zs_in     = 1'b1;
            s2_co_in     = 1'b1;
         end
         FUNC_XOR: begin
            s2_result_in = d_val ^ s_val;
            s2_zs_in     = 1'b1;
            s2_co_in     = 1'b1;
         end
         FUNC_OR: begin
            s2_result_in = d_val | s_val;
            s2_zs_in     = 1'b1;
            s2_co_in     = 1'b1;
         end
         FUNC_ROL: begin
            s2_result_in = rol_val;
         end
         FUNC_SAR: begin
            s2_result_in = sar_val;
            s2_zs_in     = 1'b1;
         end
         FUNC_SHL: begin
            s2_result_in = (d_val << cnt) & mask;
            s2_zs_in     = 1'b1;
         end
         FUNC_SHR: begin
            s2_result_in = d_val >> cnt;
            s2_zs_in     = 1'b1;
         end
         FUNC_NOT: begin
            s2_result_in = ~d_val & mask;
         end
         default: begin
            s2_wb_in = 1'b0;
         end
      endcase
      s2_zf_in = s2_zs_in && (s2_result_in == '0);
      s2_sf_in = s2_zs_in && ((s2_result_in & top) != '0);
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         s2_result_ff <= s2_result_in;
         s2_wb_ff     <= s2_wb_in;
         s2_zf_ff     <= s2_zf_in;
         s2_sf_ff     <= s2_sf_in;
         s2_zs_ff     <= s2_zs_in;
         s2_co_ff     <= s2_co_in;
      end
   end

   assign rsp_chan.valid         = s2_valid_ff;
   assign rsp_chan.result        = s2_result_ff;
   assign rsp_chan.write_back    = s2_wb_ff;
   assign rsp_chan.zero_flag     = s2_zf_ff;
   assign rsp_chan.sign_flag     = s2_sf_ff;
   assign rsp_chan.zs_valid      = s2_zs_ff;
   assign rsp_chan.carry_flag    = 1'b0;
   assign rsp_chan.overflow_flag = 1'b0;
   assign rsp_chan.co_valid      = s2_co_ff;

   `XLSA_ASSERT_NEXT(a_req_beat_fills_stage, req_beat, s1_valid_ff,
      "accepted beat not held in input stage")
   `XLSA_ASSERT_NEXT(a_stall_keeps_input, s1_valid_ff && !s2_load,
      s1_valid_ff && $stable(s1_dest_ff), "input stage lost beat while stalled")
   `XLSA_ASSERT_NOW(a_flags_need_valid, rsp_chan.valid && !rsp_chan.zs_valid,
      !rsp_chan.zero_flag && !rsp_chan.sign_flag, "zero or sign flag set without zs_valid")
   `XLSA_ASSERT_NOW(a_co_implies_zs, rsp_chan.valid && rsp_chan.co_valid,
      rsp_chan.zs_valid, "logic op without zero and sign update")
   `XLSA_ASSERT_NOW(a_no_wb_result, rsp_chan.valid && !rsp_chan.write_back,
      rsp_chan.co_valid || rsp_chan.result == '0, "unknown op returned nonzero result")

endmodule
